// ----- hdl/bq_pkg.sv -----
// Shared constants, types and helpers for the biquad direct form 1 filter.
`default_nettype none

package bq_pkg;

    // Data path widths
    localparam int WORD_W  = 32;
    localparam int ACC_W   = 2 * WORD_W;
    localparam int SHIFT_W = 5;

    // Channel history sets
    localparam int NUM_CHANNELS = 2;
    localparam int HIST_IDX_W   = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

    // Configuration register file
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = WORD_W;

    typedef logic signed [WORD_W-1:0]  word_t;
    typedef logic signed [ACC_W-1:0]   acc_t;
    typedef logic        [SHIFT_W-1:0] shift_t;
    typedef logic        [HIST_IDX_W-1:0] hist_idx_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_GAIN_X0   = 3'd0,
        REG_GAIN_X1   = 3'd1,
        REG_GAIN_X2   = 3'd2,
        REG_GAIN_Y1   = 3'd3,
        REG_GAIN_Y2   = 3'd4,
        REG_OUT_SHIFT = 3'd5
    } cfg_index_t;

    localparam word_t  GAIN_X0_RESET   = 32'sh1000_0000;
    localparam word_t  GAIN_RESET      = '0;
    localparam shift_t OUT_SHIFT_RESET = 5'd4;

    // Coefficients and output scaling as seen by the data path
    typedef struct packed {
        word_t  gain_x0;
        word_t  gain_x1;
        word_t  gain_x2;
        word_t  gain_y1;
        word_t  gain_y2;
        shift_t out_shift;
    } coef_t;

    // Past samples of one channel
    typedef struct packed {
        word_t in1;
        word_t in2;
        word_t out1;
        word_t out2;
    } hist_t;

    // Channel number to history set (channel modulo set count)
    function automatic hist_idx_t chan_index(input logic chan);
        hist_idx_t idx;
        if (NUM_CHANNELS == 1)
        begin
            idx = '0;
        end
        else
        begin
            idx = hist_idx_t'(chan);
        end
        return idx;
    endfunction

endpackage

`default_nettype wire

// ----- hdl/bq_if.sv -----
// Valid/ready channel interfaces: samples in, filtered samples out, register writes.
`default_nettype none

interface bq_sample_if
    import bq_pkg::*;
();
    logic        valid;
    logic        ready;
    word_t       sample_in;
    logic        chan;
    logic        block_end;

    modport source (output valid, sample_in, chan, block_end, input ready);
    modport sink   (input valid, sample_in, chan, block_end, output ready);
endinterface

interface bq_result_if
    import bq_pkg::*;
();
    logic        valid;
    logic        ready;
    word_t       sample_out;
    logic        out_chan;
    logic        out_block_end;

    modport source (output valid, sample_out, out_chan, out_block_end, input ready);
    modport sink   (input valid, sample_out, out_chan, out_block_end, output ready);
endinterface

interface bq_cfg_if
    import bq_pkg::*;
();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ----- hdl/bq_cfg_regs.sv -----
// Coefficient and output shift register file behind the configuration channel.
`default_nettype none

module bq_cfg_regs
    import bq_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    bq_cfg_if.sink      cfg,
    output coef_t       coef
);

    coef_t coef_reg;
    coef_t coef_next;
    logic  wr_beat;

    // Writes are always taken
    assign cfg.ready = 1'b1;
    assign wr_beat   = cfg.valid;

    // Register decode; unknown indexes are dropped
    always_comb
    begin
        coef_next = coef_reg;
        if (wr_beat)
        begin
            unique case (cfg.index)
                REG_GAIN_X0:   coef_next.gain_x0   = word_t'(cfg.data);
                REG_GAIN_X1:   coef_next.gain_x1   = word_t'(cfg.data);
                REG_GAIN_X2:   coef_next.gain_x2   = word_t'(cfg.data);
                REG_GAIN_Y1:   coef_next.gain_y1   = word_t'(cfg.data);
                REG_GAIN_Y2:   coef_next.gain_y2   = word_t'(cfg.data);
                REG_OUT_SHIFT: coef_next.out_shift = cfg.data[SHIFT_W-1:0];
                default:       coef_next = coef_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_reg.gain_x0   <= GAIN_X0_RESET;
            coef_reg.gain_x1   <= GAIN_RESET;
            coef_reg.gain_x2   <= GAIN_RESET;
            coef_reg.gain_y1   <= GAIN_RESET;
            coef_reg.gain_y2   <= GAIN_RESET;
            coef_reg.out_shift <= OUT_SHIFT_RESET;
        end
        else
        begin
            coef_reg <= coef_next;
        end
    end

    assign coef = coef_reg;

endmodule

`default_nettype wire

// ----- hdl/bq_history.sv -----
// Per-channel delay line: two past inputs and two past outputs for each channel.
`default_nettype none

module bq_history
    import bq_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire hist_idx_t rd_idx,
    output hist_t          hist,
    input  wire logic      wr_en,
    input  wire hist_idx_t wr_idx,
    input  wire word_t     wr_x,
    input  wire word_t     wr_y
);

    word_t prev_in1_reg  [NUM_CHANNELS];
    word_t prev_in2_reg  [NUM_CHANNELS];
    word_t prev_out1_reg [NUM_CHANNELS];
    word_t prev_out2_reg [NUM_CHANNELS];

    // Read port for the item in the input stage
    always_comb
    begin
        hist.in1  = prev_in1_reg[rd_idx];
        hist.in2  = prev_in2_reg[rd_idx];
        hist.out1 = prev_out1_reg[rd_idx];
        hist.out2 = prev_out2_reg[rd_idx];
    end

    // Shift the selected channel's history along
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_CHANNELS; i++)
            begin
                prev_in1_reg[i]  <= '0;
                prev_in2_reg[i]  <= '0;
                prev_out1_reg[i] <= '0;
                prev_out2_reg[i] <= '0;
            end
        end
        else if (wr_en)
        begin
            prev_in2_reg[wr_idx]  <= prev_in1_reg[wr_idx];
            prev_in1_reg[wr_idx]  <= wr_x;
            prev_out2_reg[wr_idx] <= prev_out1_reg[wr_idx];
            prev_out1_reg[wr_idx] <= wr_y;
        end
    end

    // New input lands in the first tap
    a_in1_update: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |=> prev_in1_reg[$past(wr_idx)] == $past(wr_x))
        else $error("input history not updated");

    // Output history moves along by one
    a_out2_shift: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |=> prev_out2_reg[$past(wr_idx)] == $past(prev_out1_reg[wr_idx]))
        else $error("output history did not shift");

endmodule

`default_nettype wire

// ----- hdl/bq_mac.sv -----
// Five-term multiply-accumulate, output shift and upper-word extraction.
`default_nettype none

module bq_mac
    import bq_pkg::*;
(
    input  wire word_t  x,
    input  wire hist_t  hist,
    input  wire coef_t  coef,
    output word_t       y
);

    acc_t p_x0;
    acc_t p_x1;
    acc_t p_x2;
    acc_t p_y1;
    acc_t p_y2;
    acc_t acc;
    acc_t acc_sh;

    // Signed 32x32 products, full 64-bit
    always_comb
    begin
        p_x0 = acc_t'(x)         * acc_t'(coef.gain_x0);
        p_x1 = acc_t'(hist.in1)  * acc_t'(coef.gain_x1);
        p_x2 = acc_t'(hist.in2)  * acc_t'(coef.gain_x2);
        p_y1 = acc_t'(hist.out1) * acc_t'(coef.gain_y1);
        p_y2 = acc_t'(hist.out2) * acc_t'(coef.gain_y2);
    end

    // Wrapping sum, feedback gains are already negated
    assign acc    = p_x0 + p_x1 + p_x2 + p_y1 + p_y2;
    assign acc_sh = acc <<< coef.out_shift;
    assign y      = acc_sh[ACC_W-1:WORD_W];

endmodule

`default_nettype wire

// ----- hdl/biquad_direct_form1_filter.sv -----
// Top level: two-channel biquad direct form 1 section with input and result registers.
//
//  Channel   Dir  Beat payload
//  samples   in   sample_in (s32), chan (1), block_end (1)
//  results   out  sample_out (s32), out_chan (1), out_block_end (1)
//  cfg       in   index (3), data (32); always ready
//
//  A sample loads the input stage register at its input beat and the result
//  register as it advances, so its result beat trails both; one sample a cycle
//  is sustained while results are taken, set by the single registered MAC pass.
//  A same-channel sample may follow directly: history updates as a result loads.
//  Reset clears coefficients to their defaults and every channel's history to zero.
//  A stalled result holds the input stage; the input takes a beat while the
//  input stage is empty or the result register is free or draining.
`default_nettype none

module biquad_direct_form1_filter
    import bq_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    bq_sample_if.sink    samples,
    bq_result_if.source  results,
    bq_cfg_if.sink       cfg
);

    coef_t coef;
    hist_t hist;
    word_t mac_y;

    logic      s1_valid_reg;
    logic      s1_valid_next;
    word_t     s1_x_reg;
    logic      s1_chan_reg;
    logic      s1_be_reg;

    logic      out_valid_reg;
    logic      out_valid_next;
    word_t     out_sample_reg;
    logic      out_chan_reg;
    logic      out_be_reg;

    logic      out_free;
    logic      s1_advance;
    logic      in_beat;
    hist_idx_t s1_idx;

    bq_cfg_regs u_cfg_regs (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .coef  (coef)
    );

    assign s1_idx = chan_index(s1_chan_reg);

    bq_history u_history (
        .clk    (clk),
        .rst_n  (rst_n),
        .rd_idx (s1_idx),
        .hist   (hist),
        .wr_en  (s1_advance),
        .wr_idx (s1_idx),
        .wr_x   (s1_x_reg),
        .wr_y   (mac_y)
    );

    bq_mac u_mac (
        .x    (s1_x_reg),
        .hist (hist),
        .coef (coef),
        .y    (mac_y)
    );

    // Handshake control
    assign out_free      = !out_valid_reg || results.ready;
    assign s1_advance    = s1_valid_reg && out_free;
    assign samples.ready = !s1_valid_reg || out_free;
    assign in_beat       = samples.valid && samples.ready;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (in_beat)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_advance)
        begin
            s1_valid_next = 1'b0;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (s1_advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (results.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // Valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Input stage payload
    always_ff @(posedge clk)
    begin
        if (in_beat)
        begin
            s1_x_reg    <= samples.sample_in;
            s1_chan_reg <= samples.chan;
            s1_be_reg   <= samples.block_end;
        end
    end

    // Result stage payload
    always_ff @(posedge clk)
    begin
        if (s1_advance)
        begin
            out_sample_reg <= mac_y;
            out_chan_reg   <= s1_chan_reg;
            out_be_reg     <= s1_be_reg;
        end
    end

    assign results.valid         = out_valid_reg;
    assign results.sample_out    = out_sample_reg;
    assign results.out_chan      = out_chan_reg;
    assign results.out_block_end = out_be_reg;

    // A sample leaving the input stage always shows up as a result
    a_advance_loads: assert property (@(posedge clk) disable iff (!rst_n)
        s1_advance |=> out_valid_reg)
        else $error("advanced sample missing from result register");

    // Input back-pressure only when both stages are full and the result is stalled
    a_ready_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !samples.ready |-> (s1_valid_reg && out_valid_reg && !results.ready))
        else $error("input stalled without cause");

    // A taken result with nothing behind it empties the result register
    a_drain: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && results.ready && !s1_advance) |=> !out_valid_reg)
        else $error("result repeated after beat");

endmodule

`default_nettype wire
